// ===== hdl/dss_pkg.sv =====
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types, constants and helpers of the delimiter stream splitter.
// ----------------------------------------------------------------------------
package dss_pkg;

   localparam int MAX_DELIMITER = 8;
   localparam int COUNT_WIDTH   = 32;
   localparam int DELIM_BYTES_W = 64;
   localparam int LENGTH_W      = 4;
   localparam int CNT_W         = $clog2(MAX_DELIMITER + 1);
   localparam int IDX_W         = (MAX_DELIMITER > 1) ? $clog2(MAX_DELIMITER) : 1;

   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_END  = 1'b1;

   localparam logic CSR_DELIM_BYTES  = 1'b0;
   localparam logic CSR_DELIM_LENGTH = 1'b1;

   typedef enum logic [1:0] {
      SHIFT_HOLD,
      SHIFT_ONE,
      SHIFT_LEN
   } shift_type;

   typedef enum logic [1:0] {
      ACT_STOP,
      ACT_BYTE,
      ACT_MATCH,
      ACT_FLUSH_END
   } act_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RESOLVE,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      shift_type shift;
      logic      append;
   } cell_ctrl_type;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]             out_byte;
      logic                   byte_valid;
      logic                   end_of_piece;
      logic [COUNT_WIDTH-1:0] pieces_done;
      logic [COUNT_WIDTH-1:0] bytes_done;
      logic [COUNT_WIDTH-1:0] delimiters_done;
   } rsp_type;

   function automatic logic [7:0] delim_at(input logic [DELIM_BYTES_W-1:0] d, input int j);
      delim_at = 8'(d >> (8 * j));
   endfunction

endpackage

// ===== hdl/dss_cell.sv =====
// ----------------------------------------------------------------------------
// dss_cell
// One window position: holds a pending byte, compares it against every
// delimiter position and takes its next byte from itself or a neighbor.
// ----------------------------------------------------------------------------
module dss_cell import dss_pkg::*; (
   input  logic                       clock,
   input  cell_ctrl_type              ctrl,
   input  logic [7:0]                 in_byte,
   input  logic [DELIM_BYTES_W-1:0]   delim_bytes,
   input  logic [7:0]                 near_view,
   input  logic [7:0]                 far_view,
   output logic [7:0]                 view,
   output logic [MAX_DELIMITER-1:0]   eq
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   assign view = ctrl.append ? in_byte : byte_ff;

   always_comb begin
      for (int j = 0; j < MAX_DELIMITER; j++) begin
         eq[j] = (view == delim_at(delim_bytes, j));
      end
   end

   always_comb begin
      unique case (ctrl.shift)
         SHIFT_HOLD: byte_in = view;
         SHIFT_ONE:  byte_in = near_view;
         SHIFT_LEN:  byte_in = far_view;
         default:    byte_in = byte_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

// ===== hdl/dss_out_buf.sv =====
// ----------------------------------------------------------------------------
// dss_out_buf
// Two-entry result buffer between the window logic and the rsp channel.
// ----------------------------------------------------------------------------
module dss_out_buf import dss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    room,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [1:0] occ_ff;
   logic [1:0] occ_in;
   rsp_type    slot_ff [2];
   rsp_type    slot_in [2];
   logic       pop;
   logic       wr_idx;

   assign pop       = (occ_ff != 2'd0) && !rsp_stall;
   assign room      = (occ_ff != 2'd2);
   assign rsp_valid = (occ_ff != 2'd0);
   assign rsp_data  = slot_ff[0];

   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      occ_in     = occ_ff;
      wr_idx     = pop ? occ_ff[1] : occ_ff[0];
      if (pop) begin
         slot_in[0] = slot_ff[1];
      end
      if (push) begin
         slot_in[wr_idx] = push_data;
      end
      occ_in = occ_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 2'd0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

endmodule

// ===== hdl/delimiter_stream_splitter.sv =====
// ----------------------------------------------------------------------------
// delimiter_stream_splitter
// Splits a byte stream into pieces at a 1 to 8 byte delimiter, leftmost and
// non-overlapping, through a row of window cells and a two-entry result
// buffer. Saturating counters track pieces, piece bytes and delimiters.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  req_type: command, data_byte
//   rsp      out  rsp_valid/rsp_stall  rsp_type: byte or terminator, counts
//   csr      in   csr_write            csr_index, csr_data
//
// A data byte writes at most one result at once, the rest from the
// resolve state; end of stream after data flushes the held bytes, then the
// terminator. One result is written per cycle into the result buffer while
// it has room. Synchronous reset clears state, counters and delimiter bytes,
// sets the length to 1. Resolve, flush or a full result buffer stall req.
// ----------------------------------------------------------------------------
module delimiter_stream_splitter import dss_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_write,
   input  logic                     csr_index,
   input  logic [DELIM_BYTES_W-1:0] csr_data
);

   logic [DELIM_BYTES_W-1:0] delim_bytes_ff, delim_bytes_in;
   logic [LENGTH_W-1:0]      delim_length_ff, delim_length_in;
   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     started_ff, started_in;
   logic [COUNT_WIDTH-1:0]   piece_len_ff, piece_len_in;
   logic [COUNT_WIDTH-1:0]   piece_total_ff, piece_total_in;
   logic [COUNT_WIDTH-1:0]   byte_total_ff, byte_total_in;
   logic [COUNT_WIDTH-1:0]   delim_total_ff, delim_total_in;

   logic                     room;
   logic                     accept;
   logic                     acc_data;
   logic                     acc_eos;
   logic [CNT_W-1:0]         eff_len;
   logic [CNT_W-1:0]         cv;
   logic [CNT_W-1:0]         newc;
   logic [MAX_DELIMITER-1:0] d0, d1, dl;
   logic [MAX_DELIMITER-1:0] eq_all     [MAX_DELIMITER];
   logic [7:0]               views      [MAX_DELIMITER];
   logic [7:0]               near_views [MAX_DELIMITER];
   logic [7:0]               far_views  [MAX_DELIMITER];
   logic [IDX_W:0]           far_sum    [MAX_DELIMITER];
   logic [IDX_W-1:0]         far_idx    [MAX_DELIMITER];
   cell_ctrl_type            cell_ctrl  [MAX_DELIMITER];
   act_type                  pat_act;
   act_type                  act;
   shift_type                shift;
   logic                     stable_new;
   logic                     push;
   rsp_type                  push_data;

   function automatic logic prefix_ok(input logic [MAX_DELIMITER-1:0] d,
                                      input logic [CNT_W-1:0] n);
      prefix_ok = &(d | ({MAX_DELIMITER{1'b1}} << n));
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
      sat_inc = (&c) ? c : c + 1'b1;
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                      input logic [COUNT_WIDTH-1:0] b);
      logic [COUNT_WIDTH:0] s;
      s       = {1'b0, a} + {1'b0, b};
      sat_add = s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
   endfunction

   // Configuration
   always_comb begin
      delim_bytes_in  = delim_bytes_ff;
      delim_length_in = delim_length_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_DELIM_BYTES:  delim_bytes_in  = csr_data;
            CSR_DELIM_LENGTH: delim_length_in = csr_data[LENGTH_W-1:0];
            default:          delim_bytes_in  = delim_bytes_ff;
         endcase
      end
   end

   always_comb begin
      if (delim_length_ff == '0) begin
         eff_len = CNT_W'(1);
      end else if (int'(delim_length_ff) > MAX_DELIMITER) begin
         eff_len = CNT_W'(MAX_DELIMITER);
      end else begin
         eff_len = CNT_W'(delim_length_ff);
      end
   end

   // Handshake
   always_comb begin
      req_stall = (state_ff != ST_IDLE) || !room;
   end

   assign accept   = req_valid && !req_stall;
   assign acc_data = accept && (req_data.command == CMD_DATA);
   assign acc_eos  = accept && (req_data.command == CMD_END);
   assign cv       = count_ff + CNT_W'(acc_data);

   // Window cells
   for (genvar i = 0; i < MAX_DELIMITER; i++) begin : g_cell
      assign cell_ctrl[i] = '{shift: shift, append: acc_data && (count_ff == CNT_W'(i))};
      assign d0[i]        = eq_all[i][i];
      if (i < MAX_DELIMITER - 1) begin : g_mid
         assign near_views[i] = views[i+1];
         assign d1[i]         = eq_all[i+1][i];
      end else begin : g_last
         assign near_views[i] = '0;
         assign d1[i]         = 1'b1;
      end
      dss_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl[i]),
         .in_byte     (req_data.data_byte),
         .delim_bytes (delim_bytes_ff),
         .near_view   (near_views[i]),
         .far_view    (far_views[i]),
         .view        (views[i]),
         .eq          (eq_all[i])
      );
   end

   always_comb begin
      for (int i = 0; i < MAX_DELIMITER; i++) begin
         far_sum[i] = (IDX_W+1)'(i) + (IDX_W+1)'(eff_len);
         far_idx[i] = far_sum[i][IDX_W-1:0];
         if (far_sum[i] < (IDX_W+1)'(MAX_DELIMITER)) begin
            far_views[i] = views[far_idx[i]];
            dl[i]        = eq_all[far_idx[i]][i];
         end else begin
            far_views[i] = '0;
            dl[i]        = 1'b1;
         end
      end
   end

   // Match decode
   always_comb begin
      if (cv >= eff_len) begin
         pat_act = prefix_ok(d0, eff_len) ? ACT_MATCH : ACT_BYTE;
      end else begin
         pat_act = prefix_ok(d0, cv) ? ACT_STOP : ACT_BYTE;
      end
   end

   always_comb begin
      unique case (state_ff)
         ST_IDLE:    act = acc_data ? pat_act : ACT_STOP;
         ST_RESOLVE: act = room ? pat_act : ACT_STOP;
         ST_FLUSH: begin
            if (!room) begin
               act = ACT_STOP;
            end else if (count_ff != '0) begin
               act = ACT_BYTE;
            end else begin
               act = ACT_FLUSH_END;
            end
         end
         default:    act = ACT_STOP;
      endcase
   end

   always_comb begin
      unique case (act)
         ACT_BYTE: begin
            newc       = cv - CNT_W'(1);
            shift      = SHIFT_ONE;
            stable_new = (newc < eff_len) && prefix_ok(d1, newc);
         end
         ACT_MATCH: begin
            newc       = cv - eff_len;
            shift      = SHIFT_LEN;
            stable_new = (newc < eff_len) && prefix_ok(dl, newc);
         end
         ACT_FLUSH_END: begin
            newc       = '0;
            shift      = SHIFT_HOLD;
            stable_new = 1'b1;
         end
         ACT_STOP: begin
            newc       = cv;
            shift      = SHIFT_HOLD;
            stable_new = 1'b1;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc_eos && started_ff) begin
               state_in = ST_FLUSH;
            end else if ((act != ACT_STOP) && !stable_new) begin
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            if ((act != ACT_STOP) && stable_new) begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (act == ACT_FLUSH_END) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Stream state, counters and result
   always_comb begin
      count_in       = newc;
      started_in     = started_ff;
      piece_len_in   = piece_len_ff;
      piece_total_in = piece_total_ff;
      byte_total_in  = byte_total_ff;
      delim_total_in = delim_total_ff;

      if (acc_data) begin
         started_in = 1'b1;
      end else if (acc_eos) begin
         started_in = 1'b0;
      end

      unique case (act)
         ACT_BYTE: begin
            piece_len_in = sat_inc(piece_len_ff);
         end
         ACT_MATCH: begin
            delim_total_in = sat_inc(delim_total_ff);
            piece_total_in = sat_inc(piece_total_ff);
            byte_total_in  = sat_add(byte_total_ff, piece_len_ff);
            piece_len_in   = '0;
         end
         ACT_FLUSH_END: begin
            piece_total_in = sat_inc(piece_total_ff);
            byte_total_in  = sat_add(byte_total_ff, piece_len_ff);
            piece_len_in   = '0;
         end
         ACT_STOP: begin
            piece_len_in = piece_len_ff;
         end
      endcase

      push                      = (act != ACT_STOP);
      push_data.out_byte        = (act == ACT_BYTE) ? views[0] : 8'd0;
      push_data.byte_valid      = (act == ACT_BYTE);
      push_data.end_of_piece    = (act == ACT_MATCH) || (act == ACT_FLUSH_END);
      push_data.pieces_done     = piece_total_in;
      push_data.bytes_done      = byte_total_in;
      push_data.delimiters_done = delim_total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_bytes_ff  <= '0;
         delim_length_ff <= LENGTH_W'(1);
         state_ff        <= ST_IDLE;
         count_ff        <= '0;
         started_ff      <= 1'b0;
         piece_len_ff    <= '0;
         piece_total_ff  <= '0;
         byte_total_ff   <= '0;
         delim_total_ff  <= '0;
      end else begin
         delim_bytes_ff  <= delim_bytes_in;
         delim_length_ff <= delim_length_in;
         state_ff        <= state_in;
         count_ff        <= count_in;
         started_ff      <= started_in;
         piece_len_ff    <= piece_len_in;
         piece_total_ff  <= piece_total_in;
         byte_total_ff   <= byte_total_in;
         delim_total_ff  <= delim_total_in;
      end
   end

   dss_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/dss_checker.sv =====
// ----------------------------------------------------------------------------
// dss_checker
// Port-level checks on the result channel of the delimiter stream splitter.
// ----------------------------------------------------------------------------
module dss_checker import dss_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic rsp_xfer;

   assign rsp_xfer = rsp_valid && !rsp_stall;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp transaction changed or dropped");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp transaction right after reset");

   a_rsp_format: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.byte_valid != rsp_data.end_of_piece) &&
                    (rsp_data.byte_valid || (rsp_data.out_byte == 8'd0)))
      else $error("rsp transaction is neither a clean byte nor a clean terminator");

   a_piece_step: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && $past(rsp_xfer && rsp_data.byte_valid) |->
         ((rsp_data.pieces_done - $past(rsp_data.pieces_done)) <= 32'd1))
      else $error("piece count jumped after a byte transaction");

endmodule

bind delimiter_stream_splitter dss_checker u_dss_checker (.*);

// ===== sim/delimiter_stream_splitter_tb.sv =====
// ----------------------------------------------------------------------------
// delimiter_stream_splitter_tb
// Drives byte streams and end-of-stream marks through the splitter under
// several delimiter settings, predicts every piece byte and terminator with
// running counts, and checks each result transaction in order. Both sides
// idle at random, and the result side holds off once long enough to back up
// the input.
// ----------------------------------------------------------------------------
module delimiter_stream_splitter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dss_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 24;
   localparam int LONG_HOLD      = 120;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_ITEMS    = 35;

   class piece_tracker;
      logic [DELIM_BYTES_W-1:0] delim_word;
      logic [LENGTH_W-1:0]      delim_len;
      logic [7:0]               window [MAX_DELIMITER];
      int                       held;
      bit                       started;
      logic [COUNT_WIDTH-1:0]   piece_len;
      logic [COUNT_WIDTH-1:0]   pieces;
      logic [COUNT_WIDTH-1:0]   piece_bytes;
      logic [COUNT_WIDTH-1:0]   delims;
      rsp_type                  due_outputs [$];
      int                       mismatches;

      function new();
         delim_word  = '0;
         delim_len   = 1;
         held        = 0;
         started     = 0;
         piece_len   = '0;
         pieces      = '0;
         piece_bytes = '0;
         delims      = '0;
         mismatches  = 0;
         foreach (window[i]) window[i] = 8'h00;
      endfunction

      function void write_register(logic idx, logic [DELIM_BYTES_W-1:0] value);
         if (idx == CSR_DELIM_BYTES) delim_word = value;
         else delim_len = value[LENGTH_W-1:0];
      endfunction

      function logic [COUNT_WIDTH-1:0] bump(logic [COUNT_WIDTH-1:0] a,
                                            logic [COUNT_WIDTH-1:0] b);
         logic [COUNT_WIDTH:0] sum;
         sum = {1'b0, a} + {1'b0, b};
         return sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
      endfunction

      function bit front_matches(int n);
         for (int i = 0; i < n; i++)
            if (window[i] != delim_word[8*i +: 8]) return 0;
         return 1;
      endfunction

      function void drop_front(int n);
         for (int i = 0; i + n < held; i++) window[i] = window[i + n];
         held -= n;
      endfunction

      function void log_output(logic [7:0] b, logic is_byte, logic is_end);
         rsp_type r;
         r.out_byte        = b;
         r.byte_valid      = is_byte;
         r.end_of_piece    = is_end;
         r.pieces_done     = pieces;
         r.bytes_done      = piece_bytes;
         r.delimiters_done = delims;
         due_outputs.push_back(r);
      endfunction

      function void emit_byte();
         logic [7:0] b;
         b = window[0];
         drop_front(1);
         piece_len = bump(piece_len, 1);
         log_output(b, 1'b1, 1'b0);
      endfunction

      function void emit_end();
         pieces      = bump(pieces, 1);
         piece_bytes = bump(piece_bytes, piece_len);
         piece_len   = '0;
         log_output(8'h00, 1'b0, 1'b1);
      endfunction

      function void note_request(req_type r);
         int len;
         len = (delim_len == 0) ? 1 : (delim_len > MAX_DELIMITER) ? MAX_DELIMITER : delim_len;
         if (r.command == CMD_END) begin
            if (started) begin
               while (held > 0) emit_byte();
               emit_end();
            end
            held      = 0;
            started   = 0;
            piece_len = '0;
            return;
         end
         started = 1;
         window[held] = r.data_byte;
         held++;
         while (held > 0) begin
            if (held >= len) begin
               if (front_matches(len)) begin
                  drop_front(len);
                  delims = bump(delims, 1);
                  emit_end();
               end else begin
                  emit_byte();
               end
            end else if (front_matches(held)) begin
               break;
            end else begin
               emit_byte();
            end
         end
      endfunction

      function void compare(string field, logic [COUNT_WIDTH-1:0] want,
                            logic [COUNT_WIDTH-1:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (due_outputs.size() == 0) begin
            $display("%0t: result expected none actual %h", $time, got);
            mismatches++;
            return;
         end
         want = due_outputs.pop_front();
         compare("out_byte", want.out_byte, got.out_byte);
         compare("byte_valid", want.byte_valid, got.byte_valid);
         compare("end_of_piece", want.end_of_piece, got.end_of_piece);
         compare("pieces_done", want.pieces_done, got.pieces_done);
         compare("bytes_done", want.bytes_done, got.bytes_done);
         compare("delimiters_done", want.delimiters_done, got.delimiters_done);
      endfunction

      function int outstanding();
         return due_outputs.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_type                  req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_write = 1'b0;
   logic                     csr_index = CSR_DELIM_BYTES;
   logic [DELIM_BYTES_W-1:0] csr_data  = '0;

   piece_tracker tracker;
   int           send_gap_max = 9;
   int           rsp_gap_max  = 9;
   bit           hold_rsp     = 0;

   delimiter_stream_splitter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic send(input logic cmd, input logic [7:0] b);
      int      gap;
      req_type item;
      gap = $urandom_range(0, send_gap_max);
      item.command   = cmd;
      item.data_byte = b;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      tracker.note_request(item);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.outstanding() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [DELIM_BYTES_W-1:0] word,
                            input logic [LENGTH_W-1:0] len);
      logic [DELIM_BYTES_W-1:0] len_word;
      len_word = {$urandom, $urandom};
      len_word[LENGTH_W-1:0] = len;
      csr_write <= 1'b1;
      csr_index <= CSR_DELIM_BYTES;
      csr_data  <= word;
      @(posedge clock);
      tracker.write_register(CSR_DELIM_BYTES, word);
      csr_index <= CSR_DELIM_LENGTH;
      csr_data  <= len_word;
      @(posedge clock);
      tracker.write_register(CSR_DELIM_LENGTH, len_word);
      csr_write <= 1'b0;
   endtask

   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            tracker.check_response(rsp_data);
            stall_left = $urandom_range(0, rsp_gap_max);
         end
         if (hold_rsp) begin
            hold_rsp   = 0;
            stall_left = LONG_HOLD;
         end
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write || reset)
            quiet = 0;
         else
            quiet++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      logic [DELIM_BYTES_W-1:0] word;
      logic [LENGTH_W-1:0]      len;
      logic [7:0]               sym_a;
      logic [7:0]               sym_b;
      logic [7:0]               burst [$];
      int                       eff;
      int                       pick;
      int                       cut;
      int                       pos;
      int                       sent;

      tracker = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send(CMD_END, 8'hA5);
      send(CMD_DATA, 8'h00);
      send(CMD_DATA, 8'hFF);
      send(CMD_DATA, 8'h00);
      send(CMD_END, 8'hFF);
      drain();

      configure(64'hFFFF_FFFF_FF43_4241, 4'd3);
      send(CMD_DATA, 8'h41);
      send(CMD_DATA, 8'h42);
      send(CMD_DATA, 8'h41);
      send(CMD_DATA, 8'h42);
      send(CMD_DATA, 8'h43);
      send(CMD_END, 8'h00);
      send(CMD_DATA, 8'h41);
      send(CMD_DATA, 8'h42);
      send(CMD_END, 8'h5A);
      drain();

      configure(64'h1234_5678_9ABC_DE55, 4'd0);
      send(CMD_DATA, 8'h55);
      send(CMD_DATA, 8'h55);
      send(CMD_END, 8'h00);
      drain();

      configure('1, 4'd15);
      repeat (7) send(CMD_DATA, 8'hFF);
      send(CMD_DATA, 8'h00);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         case (phase)
            0: len = 4'd8;
            1: len = 4'd1;
            2: len = 4'd15;
            default: len = 4'($urandom_range(0, 15));
         endcase
         eff = (len == 0) ? 1 : (len > MAX_DELIMITER) ? MAX_DELIMITER : len;
         case ($urandom_range(0, 3))
            0: word = {$urandom, $urandom};
            1: word = {8{8'($urandom)}};
            2: begin
               sym_a = 8'($urandom);
               sym_b = 8'($urandom);
               for (int i = 0; i < 8; i++)
                  word[8*i +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
            end
            default: word = $urandom_range(0, 1) ? '1 : '0;
         endcase
         configure(word, len);
         send_gap_max = (phase % 2 == 1) ? 0 : 9;
         rsp_gap_max  = (phase % 3 == 1) ? 0 : 9;
         if (phase == 4) begin
            hold_rsp     = 1;
            send_gap_max = 0;
         end
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if (burst.size() == 0) begin
               pick = $urandom_range(0, 99);
               if (pick < 30) begin
                  for (int i = 0; i < eff; i++) burst.push_back(word[8*i +: 8]);
               end else if (pick < 40) begin
                  cut = $urandom_range(1, eff);
                  for (int i = 0; i < cut; i++) burst.push_back(word[8*i +: 8]);
               end else if (pick < 46) begin
                  send(CMD_END, 8'($urandom));
                  sent++;
               end else if (pick < 70) begin
                  pos = $urandom_range(0, eff - 1);
                  burst.push_back(word[8*pos +: 8]);
               end else begin
                  burst.push_back(8'($urandom));
               end
            end
            if (burst.size() > 0) begin
               send(CMD_DATA, burst.pop_front());
               sent++;
            end
         end
      end

      drain();
      if (tracker.mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/dss_pkg.sv
hdl/dss_cell.sv
hdl/dss_out_buf.sv
hdl/delimiter_stream_splitter.sv
hdl/dss_checker.sv
sim/delimiter_stream_splitter_tb.sv
